/* hdl/cs2rgb_pkg.sv */
// Shared constants and codes for the color space to RGB and gray converter.
package cs2rgb_pkg;

	// Default number of fraction bits in the unsigned fixed-point components
	localparam int unsigned FRACTION_BITS_DEF = 15;

	// Width of every component field on the stream ports
	localparam int unsigned FIELD_W = 16;

	// Luminance weights in percent and the rounding bias for the divide by 100
	localparam int unsigned LUM_WR    = 30;
	localparam int unsigned LUM_WG    = 59;
	localparam int unsigned LUM_WB    = 11;
	localparam int unsigned LUM_BIAS  = 50;
	localparam int unsigned LUM_SCALE = 100;

	// Color space code carried in tuser
	typedef enum logic [1:0] {
		SPACE_GRAY = 2'd0,
		SPACE_RGB  = 2'd1,
		SPACE_HSB  = 2'd2,
		SPACE_CMYK = 2'd3
	} space_t;

	// Hue sector, the integer part of six times the hue
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5,
		SEC_WRAP   = 3'd6
	} sector_t;

endpackage

/* hdl/color_space_to_rgb_and_gray_unit.sv */
// Top level of the color space to RGB and gray converter pipeline.
//
// Usage:
//   Input words arrive on the s_axis channel: tuser holds the color space
//   code (gray, RGB, HSB or CMYK) and tdata the four components in unsigned
//   fixed point with FRACTION_BITS fraction bits (1 << FRACTION_BITS is 1.0).
//   Each input word yields exactly one output word on the m_axis channel
//   with red, green, blue and a weighted gray level (0.30 R + 0.59 G + 0.11 B,
//   rounded and saturated at 1.0; gray input returns its own level).
//   Each accepted word passes through the ten register stages from the input
//   register to the output one. Throughput is one word per cycle while the
//   receiver keeps m_axis_tready high; no stage holds more than one multiplier
//   in series, the two hue product levels take two stages each and the
//   reciprocal divide by 100 takes three (multiply, remainder check, correct).
//   Reset clears every stage valid bit, so the pipe comes up empty and ready.
//   When the receiver holds m_axis_tready low with a word waiting, the whole
//   pipe freezes and s_axis_tready drops; no word is lost or repeated, and
//   bubbles inside the pipe are held in place until the stall ends.
//   Components above 1.0 are clamped to 1.0 on entry; results wider than
//   16 bits (FRACTION_BITS of 16 and up) are truncated to the field width.
module color_space_to_rgb_and_gray_unit #(
	parameter int unsigned FRACTION_BITS = cs2rgb_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // comp_a [15:0], comp_b [31:16], comp_c [47:32], comp_d [63:48]
	input  logic [1:0]  s_axis_tuser,  // color_space [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // red [15:0], green [31:16], blue [47:32], gray [63:48]
);
	import cs2rgb_pkg::*;

	localparam int unsigned FB = FRACTION_BITS;
	// value width: holds 1.0 and any 16-bit input
	localparam int unsigned VW = (FB + 1 > FIELD_W) ? FB + 1 : FIELD_W;
	localparam int unsigned PW = 2 * VW;              // product width
	localparam int unsigned HW = VW + 3;              // six times hue
	localparam int unsigned SW = VW + 7;              // weighted luminance sum
	localparam int unsigned MW = SW - 6;              // reciprocal of 100
	localparam int unsigned DW = SW + MW;             // sum times reciprocal
	localparam longint unsigned RECIP = (64'd1 << SW) / 64'(LUM_SCALE);

	localparam logic [VW-1:0] ONE      = VW'(1) << FB;
	localparam logic [PW-1:0] HALF     = PW'(1) << (FB - 1);
	localparam logic [MW-1:0] RECIP_MW = MW'(RECIP);

	// Global advance: move every stage when the output register is free or taken
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s1  <= s_axis_tvalid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: clamp components to 1.0
	// ------------------------------------------------------------------
	function automatic logic [VW-1:0] sat_one(input logic [FIELD_W-1:0] x);
		logic [VW-1:0] xw;
		xw = VW'(x);
		return (xw > ONE) ? ONE : xw;
	endfunction

	space_t        sp_s1;
	logic [VW-1:0] a_s1, b_s1, c_s1, d_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s1 <= space_t'(s_axis_tuser);
			a_s1  <= sat_one(s_axis_tdata[15:0]);
			b_s1  <= sat_one(s_axis_tdata[31:16]);
			c_s1  <= sat_one(s_axis_tdata[47:32]);
			d_s1  <= sat_one(s_axis_tdata[63:48]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: hue sector and fraction, CMYK inverse, direct channels
	// ------------------------------------------------------------------
	logic [HW-1:0]  h6;
	logic [2:0]     sec_raw;
	logic           sec_wrap;
	logic [VW-1:0]  white;
	logic [VW-1:0]  red_d, grn_d, blu_d;

	function automatic logic [VW-1:0] ink_to_chan(input logic [VW-1:0] ink,
	                                               input logic [VW-1:0] wht);
		return (ink > wht) ? '0 : wht - ink;
	endfunction

	assign h6       = (HW'(a_s1) << 2) + (HW'(a_s1) << 1);
	assign sec_raw  = h6[FB +: 3];
	assign sec_wrap = (sec_raw >= SEC_WRAP);
	assign white    = ONE - d_s1;

	always_comb begin
		case (sp_s1)
			SPACE_GRAY: begin
				red_d = a_s1;
				grn_d = a_s1;
				blu_d = a_s1;
			end
			SPACE_CMYK: begin
				red_d = ink_to_chan(a_s1, white);
				grn_d = ink_to_chan(b_s1, white);
				blu_d = ink_to_chan(c_s1, white);
			end
			default: begin
				red_d = a_s1;
				grn_d = b_s1;
				blu_d = c_s1;
			end
		endcase
	end

	space_t        sp_s2;
	sector_t       sec_s2;
	logic [VW-1:0] f_s2, omf_s2, oms_s2, s_s2, v_s2, a_s2;
	logic [VW-1:0] red_s2, grn_s2, blu_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s2  <= sp_s1;
			sec_s2 <= sec_wrap ? SEC_R_TO_Y : sector_t'(sec_raw);
			f_s2   <= sec_wrap ? '0 : VW'(h6[FB-1:0]);
			omf_s2 <= sec_wrap ? ONE : ONE - VW'(h6[FB-1:0]);
			oms_s2 <= ONE - b_s1;
			s_s2   <= b_s1;
			v_s2   <= c_s1;
			a_s2   <= a_s1;
			red_s2 <= red_d;
			grn_s2 <= grn_d;
			blu_s2 <= blu_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: s*f, s*(1-f), v*(1-s)
	// ------------------------------------------------------------------
	space_t        sp_s3;
	sector_t       sec_s3;
	logic [PW-1:0] sf_s3, sof_s3, pp_s3;
	logic [VW-1:0] v_s3, a_s3, red_s3, grn_s3, blu_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s3  <= sp_s2;
			sec_s3 <= sec_s2;
			sf_s3  <= PW'(s_s2) * PW'(f_s2);
			sof_s3 <= PW'(s_s2) * PW'(omf_s2);
			pp_s3  <= PW'(v_s2) * PW'(oms_s2);
			v_s3   <= v_s2;
			a_s3   <= a_s2;
			red_s3 <= red_s2;
			grn_s3 <= grn_s2;
			blu_s3 <= blu_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: round the first products, form 1 - s*f and 1 - s*(1-f)
	// ------------------------------------------------------------------
	function automatic logic [VW-1:0] rnd(input logic [PW-1:0] prod);
		logic [PW-1:0] sum;
		sum = prod + HALF;
		return sum[FB +: VW];
	endfunction

	space_t        sp_s4;
	sector_t       sec_s4;
	logic [VW-1:0] qs_s4, ts_s4, p_s4, v_s4, a_s4, red_s4, grn_s4, blu_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s4  <= sp_s3;
			sec_s4 <= sec_s3;
			qs_s4  <= ONE - rnd(sf_s3);
			ts_s4  <= ONE - rnd(sof_s3);
			p_s4   <= rnd(pp_s3);
			v_s4   <= v_s3;
			a_s4   <= a_s3;
			red_s4 <= red_s3;
			grn_s4 <= grn_s3;
			blu_s4 <= blu_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: v*(1 - s*f) and v*(1 - s*(1-f))
	// ------------------------------------------------------------------
	space_t        sp_s5;
	sector_t       sec_s5;
	logic [PW-1:0] qp_s5, tp_s5;
	logic [VW-1:0] p_s5, v_s5, a_s5, red_s5, grn_s5, blu_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s5  <= sp_s4;
			sec_s5 <= sec_s4;
			qp_s5  <= PW'(v_s4) * PW'(qs_s4);
			tp_s5  <= PW'(v_s4) * PW'(ts_s4);
			p_s5   <= p_s4;
			v_s5   <= v_s4;
			a_s5   <= a_s4;
			red_s5 <= red_s4;
			grn_s5 <= grn_s4;
			blu_s5 <= blu_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: round q and t, pick the channels by hue sector
	// ------------------------------------------------------------------
	logic [VW-1:0] q_val, t_val;
	logic [VW-1:0] red_h, grn_h, blu_h;

	assign q_val = rnd(qp_s5);
	assign t_val = rnd(tp_s5);

	always_comb begin
		case (sec_s5)
			SEC_R_TO_Y: begin
				red_h = v_s5;  grn_h = t_val; blu_h = p_s5;
			end
			SEC_Y_TO_G: begin
				red_h = q_val; grn_h = v_s5;  blu_h = p_s5;
			end
			SEC_G_TO_C: begin
				red_h = p_s5;  grn_h = v_s5;  blu_h = t_val;
			end
			SEC_C_TO_B: begin
				red_h = p_s5;  grn_h = q_val; blu_h = v_s5;
			end
			SEC_B_TO_M: begin
				red_h = t_val; grn_h = p_s5;  blu_h = v_s5;
			end
			default: begin
				red_h = v_s5;  grn_h = p_s5;  blu_h = q_val;
			end
		endcase
	end

	space_t        sp_s6;
	logic [VW-1:0] a_s6, red_s6, grn_s6, blu_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s6  <= sp_s5;
			a_s6   <= a_s5;
			red_s6 <= (sp_s5 == SPACE_HSB) ? red_h : red_s5;
			grn_s6 <= (sp_s5 == SPACE_HSB) ? grn_h : grn_s5;
			blu_s6 <= (sp_s5 == SPACE_HSB) ? blu_h : blu_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: weighted sum 30 R + 59 G + 11 B + 50
	// ------------------------------------------------------------------
	space_t        sp_s7;
	logic [SW-1:0] sum_s7;
	logic [VW-1:0] a_s7, red_s7, grn_s7, blu_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s7  <= sp_s6;
			sum_s7 <= SW'(LUM_WR) * SW'(red_s6) + SW'(LUM_WG) * SW'(grn_s6)
			        + SW'(LUM_WB) * SW'(blu_s6) + SW'(LUM_BIAS);
			a_s7   <= a_s6;
			red_s7 <= red_s6;
			grn_s7 <= grn_s6;
			blu_s7 <= blu_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: sum times floor(2^SW / 100); estimate is exact or one low
	// ------------------------------------------------------------------
	space_t        sp_s8;
	logic [DW-1:0] prod_s8;
	logic [SW-1:0] sum_s8;
	logic [VW-1:0] a_s8, red_s8, grn_s8, blu_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s8   <= sp_s7;
			prod_s8 <= DW'(sum_s7) * DW'(RECIP_MW);
			sum_s8  <= sum_s7;
			a_s8    <= a_s7;
			red_s8  <= red_s7;
			grn_s8  <= grn_s7;
			blu_s8  <= blu_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: remainder check for the one-low estimate
	// ------------------------------------------------------------------
	logic [VW-1:0] q_est;
	logic [SW-1:0] rem;

	assign q_est = prod_s8[SW +: VW];
	assign rem   = sum_s8 - SW'(LUM_SCALE) * SW'(q_est);

	space_t        sp_s9;
	logic [VW-1:0] q_s9, a_s9, red_s9, grn_s9, blu_s9;
	logic          up_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s9  <= sp_s8;
			q_s9   <= q_est;
			up_s9  <= (rem >= SW'(LUM_SCALE));
			a_s9   <= a_s8;
			red_s9 <= red_s8;
			grn_s9 <= grn_s8;
			blu_s9 <= blu_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: correct, saturate, choose gray source; output register
	// ------------------------------------------------------------------
	logic [VW:0]    lum;
	logic [VW-1:0]  gray_v;

	assign lum = (VW + 1)'(q_s9) + (VW + 1)'(up_s9);

	always_comb begin
		if (sp_s9 == SPACE_GRAY) begin
			gray_v = a_s9;
		end else if (lum > (VW + 1)'(ONE)) begin
			gray_v = ONE;
		end else begin
			gray_v = lum[VW-1:0];
		end
	end

	logic [FIELD_W-1:0] red_s10, grn_s10, blu_s10, gray_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			red_s10  <= red_s9[FIELD_W-1:0];
			grn_s10  <= grn_s9[FIELD_W-1:0];
			blu_s10  <= blu_s9[FIELD_W-1:0];
			gray_s10 <= gray_v[FIELD_W-1:0];
		end
	end

	assign m_axis_tvalid = valid_s10;
	assign m_axis_tdata  = {gray_s10, blu_s10, grn_s10, red_s10};

endmodule
